>>> hw/rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

	localparam logic       MODE_ENCODE = 1'b0;
	localparam logic       MODE_DECODE = 1'b1;
	localparam logic [7:0] PAD_CHAR    = 8'h3D;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// One input item's worth of results: up to four bytes.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		logic            done;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = {2'b00, v} + 8'h41;
		end else if (v < 6'd52) begin
			r = {2'b00, v} + 8'h47;
		end else if (v < 6'd62) begin
			r = {2'b00, v} - 8'h04;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

	function automatic sextet_t b64_sextet(input logic [7:0] c);
		sextet_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.val = 6'(c - 8'h47);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 6'(c + 8'h04);
		end else if (c == 8'h2B) begin
			r.val = 6'd62;
		end else if (c == 8'h2F) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/b64_if.sv
// ----------------------------------------------------------------------------
// b64_in_if / b64_out_if
// Valid/ready channels of the Base64 codec.
// ----------------------------------------------------------------------------
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       msg_end;

	modport source (output valid, output in_byte, output msg_end, input ready);
	modport sink   (input valid, input in_byte, input msg_end, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       msg_done;

	modport source (output valid, output out_byte, output run_last, output msg_done,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input msg_done,
		output ready);
endinterface

>>> hw/rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Accepts items, keeps the group state and builds one job per item that
// produces results.
// ----------------------------------------------------------------------------
module b64_front
	import b64_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	b64_in_if.sink         in_ch,
	input  logic           job_full,
	output logic           job_push,
	output job_t           job
);

	logic        mode_q;
	logic [23:0] gb_q;
	logic [1:0]  cnt_q;
	logic        halted_q;

	logic        accept;
	logic [23:0] enc_gb, enc_g;
	logic [1:0]  enc_cnt;
	logic        enc_full;
	sextet_t     sx;
	logic        dec_ok;
	logic [23:0] dec_gb, eff_gb, flush_g;
	logic [1:0]  dec_cnt, eff_cnt;
	logic        dec_full, dec_flush;
	logic        emit;

	assign in_ch.ready = !job_full;
	assign accept      = in_ch.valid && !job_full;

	assign enc_gb   = {gb_q[15:0], in_ch.in_byte};
	assign enc_cnt  = cnt_q + 2'd1;
	assign enc_full = (enc_cnt == 2'd3);

	assign sx        = b64_sextet(in_ch.in_byte);
	assign dec_ok    = !halted_q && sx.ok;
	assign dec_gb    = {gb_q[17:0], sx.val};
	assign dec_cnt   = cnt_q + 2'd1;
	assign eff_gb    = dec_ok ? dec_gb : gb_q;
	assign eff_cnt   = dec_ok ? dec_cnt : cnt_q;
	assign dec_full  = dec_ok && (dec_cnt == 2'd0);
	assign dec_flush = in_ch.msg_end && (eff_cnt > 2'd1);
	assign flush_g   = (eff_cnt == 2'd2) ? {eff_gb[11:0], 12'h000} : {eff_gb[17:0], 6'h00};

	always_comb begin
		unique case (enc_cnt)
			2'd1:    enc_g = {enc_gb[7:0], 16'h0000};
			2'd2:    enc_g = {enc_gb[15:0], 8'h00};
			default: enc_g = enc_gb;
		endcase
	end

	always_comb begin
		job.done = in_ch.msg_end;
		if (mode_q == MODE_ENCODE) begin
			emit         = enc_full || in_ch.msg_end;
			job.last_idx = 2'd3;
			for (int k = 0; k < 4; k++) begin
				job.data[3 - k] = (k <= int'(enc_cnt)) ? b64_char(enc_g[23 - 6 * k -: 6])
					: PAD_CHAR;
			end
		end else begin
			emit = dec_full || dec_flush;
			if (dec_full) begin
				job.data     = {eff_gb[23:16], eff_gb[15:8], eff_gb[7:0], 8'h00};
				job.last_idx = 2'd2;
			end else begin
				job.data     = {flush_g[23:16], flush_g[15:8], 16'h0000};
				job.last_idx = eff_cnt - 2'd2;
			end
		end
	end

	assign job_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ENCODE;
			gb_q     <= '0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q   <= cfg_wdata;
			gb_q     <= '0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.msg_end) begin
				gb_q     <= '0;
				cnt_q    <= '0;
				halted_q <= 1'b0;
			end else if (mode_q == MODE_ENCODE) begin
				gb_q  <= enc_full ? 24'h000000 : enc_gb;
				cnt_q <= enc_full ? 2'd0 : enc_cnt;
			end else begin
				gb_q     <= dec_full ? 24'h000000 : eff_gb;
				cnt_q    <= eff_cnt;
				halted_q <= halted_q || !sx.ok;
			end
		end
	end

endmodule

>>> hw/rtl/b64_fifo.sv
// ----------------------------------------------------------------------------
// b64_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64_fifo
	import b64_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic head_valid
);

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full       = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module b64_back
	import b64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      head_valid,
	output logic      pop,
	b64_out_if.source out_ch
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       msg_done_q;
	logic       load;
	logic       last;

	assign load = head_valid && (!out_valid_q || out_ch.ready);
	assign last = (idx_q == head.last_idx);
	assign pop  = load && last;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_last = run_last_q;
	assign out_ch.msg_done = msg_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.data[2'd3 - idx_q];
			run_last_q <= last;
			msg_done_q <= last && head.done;
		end
	end

endmodule

>>> hw/rtl/base64_codec_core.sv
// ----------------------------------------------------------------------------
// base64_codec_core
// Streaming Base64 codec (standard alphabet, '=' padding).
//
// in_ch carries one byte per transfer plus msg_end. out_ch carries one byte
// per transfer with run_last on the last result of an input transfer and
// msg_done on the last result of a message. cfg_we/cfg_wdata set the mode
// (0 encode, 1 decode) and drop any open group.
// A result passes the job queue and then the output register before it is
// valid on out_ch.
// Throughput: one result per cycle while out_ch is ready, set by the single
// output register. Encode then takes three bytes per four results and decode
// one character per cycle. A two-entry job queue lets input run ahead of the output.
// Reset clears mode to encode and empties group state, queue and output.
// When out_ch stalls, the output holds, the queue fills and in_ch.ready
// drops; nothing is lost.
// ----------------------------------------------------------------------------
module base64_codec_core
	import b64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	b64_in_if.sink    in_ch,
	b64_out_if.source out_ch
);

	logic job_full, job_push, pop, head_valid;
	job_t job, head;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (job)
	);

	b64_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_data  (job),
		.full       (job_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

>>> hw/rtl/b64_checker.sv
// ----------------------------------------------------------------------------
// b64_checker
// Port-level checks of the Base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       msg_done
);

	logic [1:0] run_cnt_q;
	logic       xfer;

	assign xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (xfer) begin
			run_cnt_q <= run_last ? 2'd0 : run_cnt_q + 2'd1;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out valid dropped while stalled");

	a_byte_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte))
		else $error("out byte changed while stalled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_done |-> run_last)
		else $error("msg_done without run_last");

	a_run_max_four: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && run_cnt_q == 2'd3 |-> run_last)
		else $error("more than four results for one input transfer");

endmodule

bind base64_codec_core b64_checker u_b64_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.run_last  (out_ch.run_last),
	.msg_done  (out_ch.msg_done)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_codec_core. A directed table runs first:
// known encode/decode vectors, byte extremes, halts, lone sextets and a
// mode write that drops a held group. Random encode and decode messages
// follow, under four idling phases on both channels. Each output transfer
// is checked field by field against known rows or an in-bench codec predictor.
// ----------------------------------------------------------------------------
module tb
	import b64_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WDOG_LIMIT  = 2000;
	localparam int DRAIN_GAP   = 10;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 20;

	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        known;
		logic [2:0]  n_known;
		logic [31:0] chars;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       msg_done;
	} codec_result_t;

	// known rows carry the literal output text, right-justified
	localparam dir_row_t DIR_ROWS [26] = '{
		'{ROW_ITEM, "M",    1'b0, 1'b1, 3'd0, 32'h0},
		'{ROW_ITEM, "a",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "n",    1'b0, 1'b1, 3'd4, "TWFu"},
		'{ROW_ITEM, 8'h00,  1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, 8'hFF,  1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, 8'hFF,  1'b1, 1'b1, 3'd4, "AP//"},
		'{ROW_ITEM, "f",    1'b1, 1'b1, 3'd4, "Zg=="},
		'{ROW_ITEM, "f",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "o",    1'b1, 1'b1, 3'd4, "Zm8="},
		'{ROW_ITEM, 8'hFF,  1'b1, 1'b1, 3'd4, "/w=="},
		'{ROW_MODE, 8'(MODE_DECODE), 1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "T",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "W",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "F",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "u",    1'b0, 1'b1, 3'd3, "Man"},
		'{ROW_ITEM, "Z",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "m",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "8",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "=",    1'b0, 1'b1, 3'd0, 32'h0},
		'{ROW_ITEM, "x",    1'b1, 1'b1, 3'd2, "fo"},
		'{ROW_ITEM, "Q",    1'b1, 1'b1, 3'd0, 32'h0},
		'{ROW_ITEM, 8'hFF,  1'b1, 1'b1, 3'd0, 32'h0},
		'{ROW_ITEM, "Q",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "Q",    1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_MODE, 8'(MODE_ENCODE), 1'b0, 1'b0, 3'd0, 32'h0},
		'{ROW_ITEM, "f",    1'b1, 1'b1, 3'd4, "Zg=="}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic rx_ready = 1'b0;

	b64_in_if  in_ch();
	b64_out_if out_ch();

	assign out_ch.ready = rx_ready;

	base64_codec_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	logic        cur_mode;
	logic [23:0] grp_bits;
	logic [1:0]  grp_cnt;
	logic        dec_halted;

	codec_result_t results_due[$];
	int n_errors = 0;
	int send_idle = 0;
	int rx_stall = 0;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		return B64_ALPHABET[8*(63 - int'(v)) +: 8];
	endfunction

	function automatic int codec_predict(input logic [7:0] b, input logic e,
		output logic [7:0] res [4]);
		int n;
		logic [23:0] g;
		logic [5:0] sx;
		logic hit;
		n = 0;
		sx = '0;
		hit = 1'b0;
		foreach (res[i]) res[i] = 8'h00;
		if (cur_mode == MODE_ENCODE) begin
			grp_bits = {grp_bits[15:0], b};
			grp_cnt = grp_cnt + 2'd1;
			if (grp_cnt == 2'd3) begin
				for (int i = 0; i < 4; i++) begin
					res[n] = enc_char(grp_bits[18 - 6*i +: 6]);
					n++;
				end
				grp_bits = '0;
				grp_cnt = '0;
			end
			if (e && grp_cnt != 2'd0) begin
				g = grp_bits << (8 * (3 - int'(grp_cnt)));
				for (int i = 0; i < int'(grp_cnt) + 1; i++) begin
					res[n] = enc_char(g[18 - 6*i +: 6]);
					n++;
				end
				for (int i = int'(grp_cnt); i < 3; i++) begin
					res[n] = PAD_CHAR;
					n++;
				end
			end
		end else begin
			if (!dec_halted) begin
				for (int k = 0; k < 64; k++) begin
					if (B64_ALPHABET[8*(63 - k) +: 8] == b) begin
						hit = 1'b1;
						sx = 6'(k);
					end
				end
				if (!hit) begin
					dec_halted = 1'b1;
				end else begin
					grp_bits = {grp_bits[17:0], sx};
					grp_cnt = grp_cnt + 2'd1;
					if (grp_cnt == 2'd0) begin
						for (int i = 0; i < 3; i++) begin
							res[n] = grp_bits[16 - 8*i +: 8];
							n++;
						end
						grp_bits = '0;
					end
				end
			end
			if (e && grp_cnt > 2'd1) begin
				g = grp_bits << (6 * (4 - int'(grp_cnt)));
				for (int i = 0; i < int'(grp_cnt) - 1; i++) begin
					res[n] = g[16 - 8*i +: 8];
					n++;
				end
			end
		end
		if (e) begin
			grp_bits = '0;
			grp_cnt = '0;
			dec_halted = 1'b0;
		end
		return n;
	endfunction

	// Enters and leaves just after a falling edge.
	task automatic send_item(input logic [7:0] b, input logic e, input logic known,
		input int n_known, input logic [31:0] chars);
		logic [7:0] res [4];
		int n;
		codec_result_t r;
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.in_byte = b;
		in_ch.msg_end = e;
		do @(posedge clk); while (!in_ch.ready);
		n = codec_predict(b, e, res);
		if (known) begin
			n = n_known;
			for (int k = 0; k < n; k++) res[k] = chars[8*(n - 1 - k) +: 8];
		end
		for (int k = 0; k < n; k++) begin
			r.out_byte = res[k];
			r.run_last = (k == n - 1);
			r.msg_done = (k == n - 1) && e;
			results_due.push_back(r);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (results_due.size() != 0) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_drained();
		repeat (DRAIN_GAP) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_mode = m;
		grp_bits = '0;
		grp_cnt = '0;
		dec_halted = 1'b0;
	endtask

	// Mostly well-formed text, with pads near the end and some stray bytes.
	function automatic logic [7:0] rand_text_char(input int pos, input int len);
		if (pos >= len - 2 && $urandom_range(3) == 0) return PAD_CHAR;
		if ($urandom_range(19) == 0) return 8'($urandom_range(255));
		return enc_char(6'($urandom_range(63)));
	endfunction

	always @(negedge clk) rx_ready <= ($urandom_range(99) >= rx_stall);

	always @(posedge clk) begin
		codec_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: out_byte %h run_last %b msg_done %b",
					out_ch.out_byte, out_ch.run_last, out_ch.msg_done);
				n_errors++;
			end else begin
				want = results_due.pop_front();
				if (out_ch.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
					n_errors++;
				end
				if (out_ch.run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, out_ch.run_last);
					n_errors++;
				end
				if (out_ch.msg_done !== want.msg_done) begin
					$error("msg_done: expected %b, got %b", want.msg_done, out_ch.msg_done);
					n_errors++;
				end
			end
		end
	end

	// watchdog: cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end while (quiet < WDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic        ph_mode [4];
		int          ph_idle [4];
		int          ph_stall [4];
		int          sent;
		int          len;
		logic [7:0]  b;
		logic        e;
		ph_mode  = '{MODE_DECODE, MODE_ENCODE, MODE_DECODE, MODE_ENCODE};
		ph_idle  = '{0, 69, 0, 27};
		ph_stall = '{0, 0, 69, 27};
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.msg_end = 1'b0;
		cur_mode = MODE_ENCODE;
		grp_bits = '0;
		grp_cnt = '0;
		dec_halted = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_MODE)
				set_mode(DIR_ROWS[i].data[0]);
			else
				send_item(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].known,
					int'(DIR_ROWS[i].n_known), DIR_ROWS[i].chars);
		end

		for (int p = 0; p < 4; p++) begin
			set_mode(ph_mode[p]);
			send_idle = ph_idle[p];
			rx_stall = ph_stall[p];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					if (cur_mode == MODE_ENCODE)
						b = 8'($urandom_range(255));
					else
						b = rand_text_char(k, len);
					// an occasional message runs on into the next one
					e = (k == len - 1) && ($urandom_range(5) != 0);
					if (!(cur_mode == MODE_DECODE && dec_halted)) sent++;
					send_item(b, e, 1'b0, 0, 32'h0);
				end
				if ($urandom_range(5) == 0) wait_drained();
			end
			// leave a group open for the next mode write to drop
			if ($urandom_range(1) == 1) begin
				b = (cur_mode == MODE_ENCODE) ? 8'($urandom_range(255))
					: enc_char(6'($urandom_range(63)));
				send_item(b, 1'b0, 1'b0, 0, 32'h0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/b64_pkg.sv
hw/rtl/b64_if.sv
hw/rtl/b64_front.sv
hw/rtl/b64_fifo.sv
hw/rtl/b64_back.sv
hw/rtl/base64_codec_core.sv
hw/rtl/b64_checker.sv
tb/tb.sv
